@@ hdl/rhhm_pkg.sv @@
// Shared constants for the Robin Hood hash map.
`timescale 1ns / 1ps
`default_nettype none
package rhhm_pkg;
   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_UPDATED  = 3'd1;
   localparam logic [2:0] ST_FOUND    = 3'd2;
   localparam logic [2:0] ST_MISSING  = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic       MODE_INSERT = 1'b0;
   localparam logic       MODE_LOOKUP = 1'b1;
   localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
endpackage
`default_nettype wire

@@ hdl/robin_hood_hash_map.sv @@
// Top level of the Robin Hood hash map: hashing, probe sequencer and slot memory.
// Usage:
//  req_ channel carries one operation: insert/update or lookup of a 64-bit key.
//  rsp_ channel returns one status and value per operation, in order.
//  The key is mixed by a 64-bit finaliser built from 32x32 partial products
//  before probing starts. Probing then reads one slot at a time, in a read
//  state (memory read latency) and then an evaluate state (compare and
//  write back). An insert of a new key walks its chain twice (search, then
//  placement). Probing is bounded to TABLE_SLOTS slots. One operation is
//  processed at a time and the next request is taken in the cycle its
//  predecessor's result is presented.
//  After reset the valid bits are swept clear, one slot per cycle, over all
//  TABLE_SLOTS slots; req_tready stays low meanwhile.
//  A finished result waits in the output register while the next operation
//  runs; a stalled receiver holds the sequencer once that one is finished too.
//  TABLE_SLOTS must be a power of two.
`timescale 1ns / 1ps
`default_nettype none
module robin_hood_hash_map #(
   parameter int TABLE_SLOTS = 1024
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [127:0] req_tdata, // key[63:0], new_value[127:64]
   input  wire         req_tuser,  // mode
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata   // status[2:0], read_value[66:3], zero fill
);
   import rhhm_pkg::*;
   localparam int AW = (TABLE_SLOTS > 2) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CW = AW + 1;

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001, S_IDLE = 9'b000000010, S_MIX = 9'b000000100,
      S_READ  = 9'b000001000, S_EVAL = 9'b000010000, S_INS = 9'b000100000,
      S_IREAD = 9'b001000000, S_IEVAL = 9'b010000000, S_DONE = 9'b100000000
   } state_type;

   // Slot memory: key, value, distance; valid bits in a separate memory
   logic [63:0] mem_key [TABLE_SLOTS];
   logic [63:0] mem_val [TABLE_SLOTS];
   logic [AW-1:0] mem_dist [TABLE_SLOTS];
   logic        mem_vld [TABLE_SLOTS];
   logic [63:0] rd_key, rd_val;
   logic [AW-1:0] rd_dist;
   logic        rd_vld;
   logic        we, we_vld;
   logic [AW-1:0] waddr, raddr;
   logic [63:0] wkey, wval;
   logic [AW-1:0] wdist;
   logic        wvld;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_key[waddr]  <= wkey;
         mem_val[waddr]  <= wval;
         mem_dist[waddr] <= wdist;
      end
      if (we_vld) mem_vld[waddr] <= wvld;
      rd_key  <= mem_key[raddr];
      rd_val  <= mem_val[raddr];
      rd_dist <= mem_dist[raddr];
      rd_vld  <= mem_vld[raddr];
   end

   state_type state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] home_ff, home_in;
   logic [CW-1:0] dist_ff, dist_in;   // probe count, also loop bound
   logic [CW-1:0] count_ff, count_in;
   logic [63:0] ck_ff, ck_in, cv_ff, cv_in;
   logic [AW-1:0] cd_ff, cd_in;
   logic        mode_ff, mode_in;
   logic [3:0]  step_ff, step_in;
   logic [63:0] mk_ff, mk_in;
   logic [63:0] pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in;
   logic [2:0]  st_ff, st_in;
   logic [63:0] rv_ff, rv_in;
   logic [2:0]  pst_ff, pst_in;
   logic [63:0] prv_ff, prv_in;
   logic        ov_ff, ov_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {5'd0, rv_ff, st_ff};

   logic [63:0] xs;
   logic [63:0] mulc;
   logic [AW-1:0] nidx;
   logic        dist_lt;
   always_comb begin
      xs   = mk_ff ^ (mk_ff >> 33);
      mulc = (step_ff < 4'd5) ? MIX_C1 : MIX_C2;
      nidx = idx_ff + AW'(1);
      // distance of resident compared with carried/probe distance
      dist_lt = ({1'b0, rd_dist} < dist_ff);
   end

   always_comb begin
      state_in = state_ff; idx_in = idx_ff; home_in = home_ff; dist_in = dist_ff;
      count_in = count_ff; ck_in = ck_ff; cv_in = cv_ff; cd_in = cd_ff;
      mode_in = mode_ff; step_in = step_ff; mk_in = mk_ff;
      pa_in = pa_ff; pb_in = pb_ff; pc_in = pc_ff;
      st_in = st_ff; rv_in = rv_ff; ov_in = ov_ff;
      pst_in = pst_ff; prv_in = prv_ff;
      raddr = idx_ff; waddr = idx_ff; we = 1'b0; we_vld = 1'b0;
      wkey = ck_ff; wval = cv_ff; wdist = cd_ff; wvld = 1'b1;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            we_vld = 1'b1; wvld = 1'b0;
            idx_in = nidx;
            if (idx_ff == AW'(TABLE_SLOTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               mode_in = req_tuser;
               mk_in = req_tdata[63:0];
               cv_in = req_tdata[127:64];
               step_in = 4'd0;
               state_in = S_MIX;
            end
         end
         S_MIX: begin
            // xor-shift then 64x64 low product from three 32x32 products
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd0, 4'd5: mk_in = xs;
               4'd1, 4'd6: begin
                  pa_in = {32'd0, mk_ff[31:0]} * {32'd0, mulc[31:0]};
                  pb_in = {32'd0, mk_ff[63:32]} * {32'd0, mulc[31:0]};
                  pc_in = {32'd0, mk_ff[31:0]} * {32'd0, mulc[63:32]};
               end
               4'd2, 4'd7: mk_in = pa_ff + {pb_ff[31:0] + pc_ff[31:0], 32'd0};
               4'd3, 4'd4, 4'd8: ;
               default: begin
                  mk_in = xs;
                  ck_in = xs;
                  idx_in = xs[AW-1:0];
                  home_in = xs[AW-1:0];
                  dist_in = '0;
                  state_in = S_READ;
               end
            endcase
         end
         S_READ: begin
            raddr = idx_ff;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (!rd_vld || dist_lt || dist_ff == CW'(TABLE_SLOTS)) begin
               if (mode_ff == MODE_LOOKUP) begin
                  pst_in = ST_MISSING; prv_in = '0; state_in = S_DONE;
               end else if (count_ff >= CW'(TABLE_SLOTS)) begin
                  pst_in = ST_FULL; prv_in = '0; state_in = S_DONE;
               end else begin
                  idx_in = home_ff; dist_in = '0; cd_in = '0; state_in = S_IREAD;
               end
            end else if (rd_key == mk_ff) begin
               if (mode_ff == MODE_LOOKUP) begin
                  pst_in = ST_FOUND; prv_in = rd_val;
               end else begin
                  we = 1'b1; wkey = rd_key; wval = cv_ff; wdist = rd_dist;
                  pst_in = ST_UPDATED; prv_in = '0;
               end
               state_in = S_DONE;
            end else begin
               idx_in = nidx; dist_in = dist_ff + CW'(1);
               state_in = S_READ;
            end
         end
         S_IREAD: begin
            raddr = idx_ff;
            state_in = S_IEVAL;
         end
         S_IEVAL: begin
            if (!rd_vld) begin
               we = 1'b1; we_vld = 1'b1;
               count_in = count_ff + CW'(1);
               pst_in = ST_INSERTED; prv_in = '0;
               state_in = S_DONE;
            end else begin
               if (dist_lt) begin
                  we = 1'b1;
                  ck_in = rd_key; cv_in = rd_val; cd_in = rd_dist + AW'(1);
                  dist_in = {1'b0, rd_dist} + CW'(1);
               end else begin
                  cd_in = cd_ff + AW'(1); dist_in = dist_ff + CW'(1);
               end
               idx_in = nidx;
               state_in = S_IREAD;
            end
         end
         S_DONE: begin
            // load the output register once it is free or being drained
            if (!ov_ff || rsp_tready) begin
               st_in = pst_ff; rv_in = prv_ff;
               ov_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; idx_ff <= '0; count_ff <= '0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; idx_ff <= idx_in; count_ff <= count_in; ov_ff <= ov_in;
      end
      home_ff <= home_in; dist_ff <= dist_in; ck_ff <= ck_in; cv_ff <= cv_in;
      cd_ff <= cd_in; mode_ff <= mode_in; step_ff <= step_in; mk_ff <= mk_in;
      pa_ff <= pa_in; pb_ff <= pb_in; pc_ff <= pc_in; st_ff <= st_in; rv_ff <= rv_in;
      pst_ff <= pst_in; prv_ff <= prv_in;
   end

`ifndef SYNTHESIS
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_SLOTS)) else $error("entry count overflow");
   a_noaccept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("ready while busy");
   a_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IEVAL && !rd_vld) |-> count_ff < CW'(TABLE_SLOTS))
      else $error("insert into full table");
   a_rv: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st_ff != ST_FOUND |-> rv_ff == 64'd0) else $error("stray value");
`endif
endmodule
`default_nettype wire
